// ----- hdl/infection_slot_event_scheduler_defines.svh -----
// ---------------------------------------------------------------------------
// Infection slot event scheduler: assertion macros
// Shared concurrent check macros, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef INFECTION_SLOT_EVENT_SCHEDULER_DEFINES_SVH
`define INFECTION_SLOT_EVENT_SCHEDULER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define ISS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies another in the same cycle
`define ISS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- hdl/iss_pkg.sv -----
// ---------------------------------------------------------------------------
// Infection slot event scheduler package
// Shared types, codes and the timer scheduling function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

	localparam int DAY_W = 20;
	localparam logic [DAY_W-1:0] DAY_MAX = 20'hFFFFF;

	// Item opcodes
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_INFECT = 2'd1,
		OP_RESET  = 2'd2
	} op_t;

	// Asexual stage of one slot
	typedef enum logic [1:0] {
		STG_INACTIVE = 2'd0,
		STG_LIVER    = 2'd1,
		STG_BLOOD    = 2'd2
	} stage_t;

	// Host state codes
	localparam logic [1:0] HS_SUSCEPTIBLE = 2'd0;
	localparam logic [1:0] HS_LIVER       = 2'd1;
	localparam logic [1:0] HS_BLOOD       = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_LIVER_DELAY = 2'd0;
	localparam logic [1:0] REG_GAMETO_DELAY = 2'd1;
	localparam logic [1:0] REG_MAX_DAY     = 2'd2;

	// Broadcast control from the top level to every slot
	typedef struct packed {
		logic             fire;
		logic             clear;
		logic [DAY_W-1:0] day;
		logic [DAY_W-1:0] never_day;
		logic [DAY_W-1:0] blood_start;
		logic [DAY_W-1:0] blood_end;
		logic [DAY_W-1:0] infective_start;
		logic [DAY_W-1:0] infective_end;
	} slot_ctl_t;

	// Status of one slot
	typedef struct packed {
		logic   busy;
		stage_t stage;
		logic   infective;
	} slot_stat_t;

	// Store a day sum, or never when it lies beyond the last day
	function automatic logic [DAY_W-1:0] sched(
		input logic [DAY_W+2:0] sum,
		input logic [DAY_W-1:0] max_day,
		input logic [DAY_W-1:0] never_day
	);
		logic [DAY_W-1:0] res;
		if (sum > {3'b000, max_day}) begin
			res = never_day;
		end else begin
			res = sum[DAY_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/iss_slot.sv -----
// ---------------------------------------------------------------------------
// Infection slot
// One slot: occupancy, stage, infective flag and four event timers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iss_slot (
	input  logic               clk,
	input  logic               arst_n,
	input  iss_pkg::slot_ctl_t  ctl,
	input  logic               load,
	output iss_pkg::slot_stat_t stat_q,
	output iss_pkg::slot_stat_t stat_d
);
	import iss_pkg::*;

	logic [DAY_W-1:0] bs_q, be_q, is_q, ie_q;
	logic [DAY_W-1:0] bs_d, be_d, is_d, ie_d;
	logic             hit_bs, hit_be, hit_is, hit_ie;

	// Match each timer against the day
	assign hit_bs = (bs_q == ctl.day);
	assign hit_be = (be_q == ctl.day);
	assign hit_is = (is_q == ctl.day);
	assign hit_ie = (ie_q == ctl.day);

	// Next slot state: clear, fire due events, or take a new infection
	always_comb begin
		stat_d = stat_q;
		bs_d   = bs_q;
		be_d   = be_q;
		is_d   = is_q;
		ie_d   = ie_q;
		if (ctl.clear) begin
			stat_d.busy      = 1'b0;
			stat_d.stage     = STG_INACTIVE;
			stat_d.infective = 1'b0;
			bs_d = ctl.never_day;
			be_d = ctl.never_day;
			is_d = ctl.never_day;
			ie_d = ctl.never_day;
		end else if (ctl.fire) begin
			// blood end wins over blood start on the same day
			if (hit_be) begin
				stat_d.stage = STG_INACTIVE;
			end else if (hit_bs) begin
				stat_d.stage = STG_BLOOD;
			end
			if (hit_ie) begin
				stat_d.infective = 1'b0;
				stat_d.busy      = 1'b0;
			end else if (hit_is) begin
				stat_d.infective = 1'b1;
			end
			if (hit_bs) bs_d = ctl.never_day;
			if (hit_be) be_d = ctl.never_day;
			if (hit_is) is_d = ctl.never_day;
			if (hit_ie) ie_d = ctl.never_day;
		end else if (load) begin
			stat_d.busy  = 1'b1;
			stat_d.stage = STG_LIVER;
			bs_d = ctl.blood_start;
			be_d = ctl.blood_end;
			is_d = ctl.infective_start;
			ie_d = ctl.infective_end;
		end
	end

	// Hold slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q.busy      <= 1'b0;
			stat_q.stage     <= STG_INACTIVE;
			stat_q.infective <= 1'b0;
			bs_q <= DAY_MAX;
			be_q <= DAY_MAX;
			is_q <= DAY_MAX;
			ie_q <= DAY_MAX;
		end else begin
			stat_q <= stat_d;
			bs_q   <= bs_d;
			be_q   <= be_d;
			is_q   <= is_d;
			ie_q   <= ie_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/infection_slot_event_scheduler.sv -----
// ---------------------------------------------------------------------------
// Infection slot event scheduler
// Per-host table of infection slots with four timed events per slot.
// ---------------------------------------------------------------------------
//  channel  handshake                     payload
//  item     start in, busy out            opcode, day, infection_days, lifespan
//  result   done out (one-cycle strobe)   host_state .. total_infections
//  config   psel/penable/pwrite, pready   paddr, pwdata, prdata
//
//  One item per cycle; busy stays low. An item is captured in the input
//  register, updates the slot table in the following cycle, and its result
//  registers onto done together with that slot table update.
//  Reset is asynchronous, active low, and sets every timer to never.
//  The result cannot be stalled; it is shown for exactly one cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module infection_slot_event_scheduler #(
	parameter int SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [19:0] day,
	input  logic [15:0] infection_days,
	input  logic [15:0] lifespan,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// result channel
	output logic        done,
	output logic [1:0]  host_state,
	output logic [3:0]  infection_count,
	output logic [3:0]  infective_count,
	output logic        is_infective,
	output logic        died,
	output logic        accepted,
	output logic [2:0]  slot_taken,
	output logic [7:0]  total_infections
);
	import iss_pkg::*;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	// configuration
	logic [9:0]       liver_q, gameto_q;
	logic [DAY_W-1:0] max_day_q;
	logic             cfg_wr;

	// input stage
	logic             valid_s1;
	logic [1:0]       op_s1;
	logic [DAY_W-1:0] day_s1;
	logic [15:0]      dur_s1;
	logic [15:0]      life_s1;

	// host state
	logic [DAY_W-1:0] death_q;
	logic [7:0]       tally_q;

	// slot table
	slot_ctl_t        ctl;
	slot_stat_t       stat_q [SLOTS];
	slot_stat_t       stat_d [SLOTS];
	logic [SLOTS-1:0] load;

	// item decode
	logic             is_tick, died_w, new_host, infect, free_found;
	logic [SLOT_W-1:0] free_idx;
	logic [31:0]      free_ext;
	logic [DAY_W-1:0] never_day;

	// timer sums
	logic [DAY_W:0]   sum_b;
	logic [DAY_W+1:0] sum_f;
	logic [DAY_W+2:0] sum_be, sum_fe, sum_death;

	// result terms
	logic [CNT_W-1:0] busy_cnt, inf_cnt;
	logic [31:0]      busy_ext, inf_ext;
	logic             any_blood, any_liver;
	logic [7:0]       tally_d;

	// result registers
	logic             done_q, died_q, acc_q, isinf_q;
	logic [1:0]       hs_q;
	logic [3:0]       busy_cnt_q, inf_cnt_q;
	logic [2:0]       taken_q;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			liver_q   <= '0;
			gameto_q  <= '0;
			max_day_q <= DAY_MAX - 20'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LIVER_DELAY:  liver_q   <= pwdata[9:0];
				REG_GAMETO_DELAY: gameto_q  <= pwdata[9:0];
				REG_MAX_DAY:      max_day_q <= pwdata[DAY_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (paddr[3:2])
			REG_LIVER_DELAY:  prdata = {22'd0, liver_q};
			REG_GAMETO_DELAY: prdata = {22'd0, gameto_q};
			REG_MAX_DAY:      prdata = {12'd0, max_day_q};
			default:          prdata = '0;
		endcase
	end

	// Capture the item transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1   <= opcode;
			day_s1  <= day;
			dur_s1  <= infection_days;
			life_s1 <= lifespan;
		end
	end

	assign never_day = (max_day_q == DAY_MAX) ? DAY_MAX : max_day_q + 20'd1;

	// Find the lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!stat_q[i].busy) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	// Decode the item
	always_comb begin
		is_tick  = 1'b0;
		died_w   = 1'b0;
		new_host = 1'b0;
		infect   = 1'b0;
		if (valid_s1) begin
			case (op_s1)
				OP_TICK: begin
					is_tick  = (day_s1 <= max_day_q);
					died_w   = is_tick && (death_q == day_s1);
					new_host = died_w;
				end
				OP_INFECT: begin
					infect = free_found;
				end
				OP_RESET: begin
					new_host = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Build timer sums for a new infection and a new death day
	assign sum_b     = {1'b0, day_s1} + {11'd0, liver_q};
	assign sum_f     = {1'b0, sum_b} + {12'd0, gameto_q};
	assign sum_be    = {2'b00, sum_b} + {7'd0, dur_s1};
	assign sum_fe    = {1'b0, sum_f} + {7'd0, dur_s1};
	assign sum_death = {3'b000, day_s1} + {7'd0, life_s1};

	// Drive the slot broadcast
	always_comb begin
		ctl.fire            = is_tick && !died_w;
		ctl.clear           = new_host;
		ctl.day             = day_s1;
		ctl.never_day       = never_day;
		ctl.blood_start     = sched({2'b00, sum_b}, max_day_q, never_day);
		ctl.blood_end       = sched(sum_be, max_day_q, never_day);
		ctl.infective_start = sched({1'b0, sum_f}, max_day_q, never_day);
		ctl.infective_end   = sched(sum_fe, max_day_q, never_day);
		for (int i = 0; i < SLOTS; i++) begin
			load[i] = infect && (free_idx == SLOT_W'(i));
		end
	end

	// Slot table
	for (genvar g = 0; g < SLOTS; g++) begin : g_slot
		iss_slot u_slot (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.load   (load[g]),
			.stat_q (stat_q[g]),
			.stat_d (stat_d[g])
		);
	end

	// Advance death day and infection tally
	always_comb begin
		tally_d = tally_q;
		if (new_host) begin
			tally_d = '0;
		end else if (infect && (tally_q != 8'hFF)) begin
			tally_d = tally_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			death_q <= DAY_MAX;
			tally_q <= '0;
		end else begin
			if (new_host) begin
				death_q <= sched(sum_death, max_day_q, never_day);
			end
			tally_q <= tally_d;
		end
	end

	// Summarize the updated slot table
	always_comb begin
		busy_cnt  = '0;
		inf_cnt   = '0;
		any_blood = 1'b0;
		any_liver = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			busy_cnt  = busy_cnt + CNT_W'(stat_d[i].busy);
			inf_cnt   = inf_cnt + CNT_W'(stat_d[i].infective);
			any_blood = any_blood | (stat_d[i].stage == STG_BLOOD);
			any_liver = any_liver | (stat_d[i].stage == STG_LIVER);
		end
	end

	assign busy_ext = 32'(busy_cnt);
	assign inf_ext  = 32'(inf_cnt);
	assign free_ext = 32'(free_idx);

	// Register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hs_q       <= any_blood ? HS_BLOOD : (any_liver ? HS_LIVER : HS_SUSCEPTIBLE);
			busy_cnt_q <= busy_ext[3:0];
			inf_cnt_q  <= inf_ext[3:0];
			isinf_q    <= (inf_cnt != '0);
			died_q     <= died_w;
			acc_q      <= infect;
			taken_q    <= infect ? free_ext[2:0] : 3'd0;
		end
	end

	assign done             = done_q;
	assign host_state       = hs_q;
	assign infection_count  = busy_cnt_q;
	assign infective_count  = inf_cnt_q;
	assign is_infective     = isinf_q;
	assign died             = died_q;
	assign accepted         = acc_q;
	assign slot_taken       = taken_q;
	assign total_infections = tally_q;

	// Checks
`include "infection_slot_event_scheduler_defines.svh"

	`ISS_ASSERT(a_latency, ((start && !busy) |-> ##2 done), "result did not follow transfer")
	`ISS_ASSERT_IMPL(a_flags, done, !(died && accepted), "death and acceptance together")
	`ISS_ASSERT_IMPL(a_taken, done && !accepted, slot_taken == 3'd0, "slot given on rejection")
	`ISS_ASSERT_IMPL(a_death, done && died, total_infections == 8'd0 && infection_count == 4'd0,
		"death left infections behind")

endmodule

`default_nettype wire
